// ===== sv/cjdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjdq_pkg
// shared types and codes of the chunked job dispatch queue
// ----------------------------------------------------------------------------
package cjdq_pkg;

  // default sizes
  localparam int DEF_HANDLE_SLOTS = 64;
  localparam int DEF_RING_SLOTS   = 256;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // fixed field widths
  localparam int HANDLE_FIELD_W = 6;
  localparam int REMAIN_W       = 9;
  localparam int COUNT_W        = 16;

  // mode codes of an incoming beat
  localparam logic [1:0] MODE_PUSH     = 2'd0;
  localparam logic [1:0] MODE_GET      = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;
  localparam logic [1:0] MODE_QUERY    = 2'd3;

  // status codes of a result beat
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_WORK     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW    = 2'd2;
  localparam logic [1:0] ST_ZERO_CHUNK  = 2'd3;

  typedef struct packed {
    logic [1:0]                mode;
    logic [7:0]                job_code;
    logic [15:0]               data_ref;
    logic [COUNT_W-1:0]        total_count;
    logic [COUNT_W-1:0]        chunk_size;
    logic [HANDLE_FIELD_W-1:0] handle_in;
  } item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [HANDLE_FIELD_W-1:0] handle_out;
    logic [7:0]                out_job_code;
    logic [15:0]               out_data_ref;
    logic [COUNT_W-1:0]        chunk_start;
    logic [COUNT_W-1:0]        chunk_count;
    logic [REMAIN_W-1:0]       remaining;
  } result_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_REJECT_ZERO,
    OP_GET,
    OP_COMPLETE,
    OP_QUERY,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [7:0]                job_code;
    logic [15:0]               data_ref;
    logic [COUNT_W-1:0]        total_count;
    logic [COUNT_W-1:0]        chunk_size;
    logic [HANDLE_FIELD_W-1:0] handle_in;
  } cmd_t;

  // ring entry body; the owner handle sits above it in the stored word
  typedef struct packed {
    logic [7:0]         job_code;
    logic [15:0]        data_ref;
    logic [COUNT_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } chunk_info_t;

  localparam int INFO_W = $bits(chunk_info_t);

endpackage

// ===== sv/cjdq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjdq_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cjdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/cjdq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjdq_front
// takes incoming beats and classifies them into back-end commands
// ----------------------------------------------------------------------------
module cjdq_front
  import cjdq_pkg::*;
#(
  parameter int HANDLE_SLOTS = DEF_HANDLE_SLOTS
) (
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  input  logic  q_full,
  input  logic  init_busy,
  output logic  q_push,
  output cmd_t  cmd
);

  logic handle_ok;

  assign handle_ok  = 32'(item.handle_in) < HANDLE_SLOTS;
  assign item_ready = !q_full && !init_busy;
  assign q_push     = item_valid && item_ready;

  always_comb begin
    cmd.job_code    = item.job_code;
    cmd.data_ref    = item.data_ref;
    cmd.total_count = item.total_count;
    cmd.chunk_size  = item.chunk_size;
    cmd.handle_in   = item.handle_in;
    case (item.mode)
      MODE_PUSH: begin
        cmd.op = (item.chunk_size == '0) ? OP_REJECT_ZERO : OP_PUSH;
      end
      MODE_GET: begin
        cmd.op = OP_GET;
      end
      MODE_COMPLETE: begin
        cmd.op = handle_ok ? OP_COMPLETE : OP_IGNORE;
      end
      MODE_QUERY: begin
        cmd.op = handle_ok ? OP_QUERY : OP_IGNORE;
      end
      default: begin
        cmd.op = OP_IGNORE;
      end
    endcase
  end

endmodule

// ===== sv/cjdq_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjdq_cmd_queue
// short command queue that decouples front and back
// ----------------------------------------------------------------------------
module cjdq_cmd_queue
  import cjdq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  input  logic pop,
  output cmd_t cmd_out,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = fill == CNT_W'(QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cjdq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjdq_back
// sequencer that owns the chunk ring, the handle counters and the result
// ----------------------------------------------------------------------------
module cjdq_back
  import cjdq_pkg::*;
#(
  parameter int HANDLE_SLOTS = DEF_HANDLE_SLOTS,
  parameter int RING_SLOTS   = DEF_RING_SLOTS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  cmd_t    q_head,
  output logic    q_pop,
  output logic    init_busy,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int HANDLE_W = $clog2(HANDLE_SLOTS);
  localparam int RING_W   = $clog2(RING_SLOTS);
  localparam int CNT_W    = $clog2(RING_SLOTS + 1);
  localparam int PROD_W   = CNT_W + COUNT_W;
  localparam int ENTRY_W  = HANDLE_W + INFO_W;
  localparam int POS_W    = COUNT_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_WRITE,
    S_GET,
    S_GET_CNT,
    S_GET_DONE,
    S_CNT_RD,
    S_CNT_UPD,
    S_RESP
  } state_t;

  state_t              state;
  cmd_t                cur;
  result_t             rsp_pend;
  logic [RING_W-1:0]   ring_head;
  logic [RING_W-1:0]   ring_tail;
  logic [CNT_W-1:0]    pending;
  logic [HANDLE_W-1:0] next_handle;
  logic [HANDLE_W-1:0] clr_idx;
  logic [HANDLE_W-1:0] push_h;
  logic [CNT_W-1:0]    chunks;
  logic [POS_W-1:0]    pos;
  logic [PROD_W-1:0]   room_elems;

  // ring ram
  logic                ring_wr_en;
  logic [ENTRY_W-1:0]  ring_wr_data;
  logic                ring_rd_en;
  logic [ENTRY_W-1:0]  ring_rd_data;
  chunk_info_t         wr_info;
  chunk_info_t         rd_info;
  logic [HANDLE_W-1:0] rd_owner;

  // counter ram
  logic                cnt_wr_en;
  logic [HANDLE_W-1:0] cnt_wr_addr;
  logic [CNT_W-1:0]    cnt_wr_data;
  logic                cnt_rd_en;
  logic [HANDLE_W-1:0] cnt_rd_addr;
  logic [CNT_W-1:0]    cnt_rd_data;
  logic [CNT_W-1:0]    cnt_upd;

  logic [HANDLE_W-1:0] cur_handle;
  logic [CNT_W-1:0]    free_slots;
  logic                more_chunks;
  logic [COUNT_W-1:0]  left;
  logic                out_free;

  assign cur_handle  = HANDLE_W'(cur.handle_in);
  assign free_slots  = CNT_W'(RING_SLOTS) - pending;
  assign more_chunks = pos < POS_W'(cur.total_count);
  assign left        = cur.total_count - pos[COUNT_W-1:0];
  assign out_free    = !result_valid || result_ready;
  assign init_busy   = state == S_CLEAR;
  assign q_pop       = state == S_IDLE && !q_empty;

  assign rd_info  = chunk_info_t'(ring_rd_data[INFO_W-1:0]);
  assign rd_owner = ring_rd_data[ENTRY_W-1 -: HANDLE_W];

  // counter after a complete; a query or a counter at zero keeps it
  assign cnt_upd = (cur.op == OP_COMPLETE && cnt_rd_data != '0) ?
                   cnt_rd_data - 1'b1 : cnt_rd_data;

  always_comb begin
    wr_info.job_code = cur.job_code;
    wr_info.data_ref = cur.data_ref;
    wr_info.start    = pos[COUNT_W-1:0];
    wr_info.count    = (left < cur.chunk_size) ? left : cur.chunk_size;
    ring_wr_data     = {push_h, wr_info};
    ring_wr_en       = state == S_WRITE && more_chunks;
    ring_rd_en       = state == S_GET && pending != '0;

    cnt_rd_en   = state == S_GET_CNT || state == S_CNT_RD;
    cnt_rd_addr = (state == S_GET_CNT) ? rd_owner : cur_handle;

    cnt_wr_en   = 1'b0;
    cnt_wr_addr = cur_handle;
    cnt_wr_data = cnt_upd;
    case (state)
      S_CLEAR: begin
        cnt_wr_en   = 1'b1;
        cnt_wr_addr = clr_idx;
        cnt_wr_data = '0;
      end
      S_WRITE: begin
        cnt_wr_en   = !more_chunks;
        cnt_wr_addr = push_h;
        cnt_wr_data = chunks;
      end
      S_CNT_UPD: begin
        cnt_wr_en = cur.op == OP_COMPLETE;
      end
      default: begin
        cnt_wr_en = 1'b0;
      end
    endcase
  end

  cjdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_SLOTS)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (ring_tail),
    .wr_data (ring_wr_data),
    .rd_en   (ring_rd_en),
    .rd_addr (ring_head),
    .rd_data (ring_rd_data)
  );

  cjdq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HANDLE_SLOTS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ring_head    <= '0;
      ring_tail    <= '0;
      pending      <= '0;
      next_handle  <= '0;
      clr_idx      <= '0;
      rsp_pend     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_RESP) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == HANDLE_W'(HANDLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_head;
            case (q_head.op)
              OP_PUSH: begin
                state <= S_MUL;
              end
              OP_REJECT_ZERO: begin
                rsp_pend.status <= ST_ZERO_CHUNK;
                state           <= S_RESP;
              end
              OP_GET: begin
                state <= S_GET;
              end
              OP_COMPLETE, OP_QUERY: begin
                state <= S_CNT_RD;
              end
              default: begin
                // handle beyond the counter table
                rsp_pend.status     <= ST_OK;
                rsp_pend.handle_out <= q_head.handle_in;
                state               <= S_RESP;
              end
            endcase
          end
        end
        S_MUL: begin
          // elements that still fit: free ring slots times chunk size
          room_elems <= PROD_W'(free_slots) * PROD_W'(cur.chunk_size);
          state      <= S_CHECK;
        end
        S_CHECK: begin
          if (PROD_W'(cur.total_count) > room_elems) begin
            rsp_pend.status <= ST_OVERFLOW;
            state           <= S_RESP;
          end else begin
            push_h      <= next_handle;
            next_handle <= (next_handle == HANDLE_W'(HANDLE_SLOTS - 1)) ?
                           '0 : next_handle + 1'b1;
            pos         <= '0;
            chunks      <= '0;
            state       <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (more_chunks) begin
            ring_tail <= (ring_tail == RING_W'(RING_SLOTS - 1)) ?
                         '0 : ring_tail + 1'b1;
            pos       <= pos + POS_W'(cur.chunk_size);
            chunks    <= chunks + 1'b1;
          end else begin
            pending             <= pending + chunks;
            rsp_pend.status     <= ST_OK;
            rsp_pend.handle_out <= HANDLE_FIELD_W'(push_h);
            rsp_pend.remaining  <= REMAIN_W'(chunks);
            state               <= S_RESP;
          end
        end
        S_GET: begin
          if (pending == '0) begin
            rsp_pend.status <= ST_NO_WORK;
            state           <= S_RESP;
          end else begin
            ring_head <= (ring_head == RING_W'(RING_SLOTS - 1)) ?
                         '0 : ring_head + 1'b1;
            pending   <= pending - 1'b1;
            state     <= S_GET_CNT;
          end
        end
        S_GET_CNT: begin
          state <= S_GET_DONE;
        end
        S_GET_DONE: begin
          rsp_pend.status       <= ST_OK;
          rsp_pend.handle_out   <= HANDLE_FIELD_W'(rd_owner);
          rsp_pend.out_job_code <= rd_info.job_code;
          rsp_pend.out_data_ref <= rd_info.data_ref;
          rsp_pend.chunk_start  <= rd_info.start;
          rsp_pend.chunk_count  <= rd_info.count;
          rsp_pend.remaining    <= REMAIN_W'(cnt_rd_data);
          state                 <= S_RESP;
        end
        S_CNT_RD: begin
          state <= S_CNT_UPD;
        end
        S_CNT_UPD: begin
          rsp_pend.status     <= ST_OK;
          rsp_pend.handle_out <= cur.handle_in;
          rsp_pend.remaining  <= REMAIN_W'(cnt_upd);
          state               <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            result       <= rsp_pend;
            result_valid <= 1'b1;
            // fields the next command leaves alone read as zero
            rsp_pend     <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/chunked_job_dispatch_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_job_dispatch_queue_unit
// job queue that splits pushed jobs into chunks with per-handle counters
// ----------------------------------------------------------------------------
// Every beat on the item channel gives exactly one beat on the result
// channel, in order. A push passes a multiply and a room check, then
// writes its chunks to the ring memory, one chunk entry per cycle; a get
// with work pending reads the ring, then the counter at the popped owner;
// a complete or query reads the handle counter and a complete writes it
// back. A zero chunk size is rejected at once, a push that does not fit
// after the room check. The back end works on one command at a time; a two
// deep command queue in front of it and the result register behind it let
// the item side and the result side stall independently. After reset the
// handle counters are cleared, and item_ready stays low during the clear.
// ----------------------------------------------------------------------------
module chunked_job_dispatch_queue_unit
  import cjdq_pkg::*;
#(
  parameter int HANDLE_SLOTS = DEF_HANDLE_SLOTS,
  parameter int RING_SLOTS   = DEF_RING_SLOTS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // front to queue
  logic q_push;
  cmd_t q_cmd_in;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  // back is sweeping the counter table
  logic init_busy;

  // classification of each incoming beat
  cjdq_front #(
    .HANDLE_SLOTS (HANDLE_SLOTS)
  ) u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .q_push     (q_push),
    .cmd        (q_cmd_in)
  );

  // decoupling queue
  cjdq_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (q_cmd_in),
    .pop     (q_pop),
    .cmd_out (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // ring, counters and result register
  cjdq_back #(
    .HANDLE_SLOTS (HANDLE_SLOTS),
    .RING_SLOTS   (RING_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // nothing enters the queue while the counters are being cleared
  assert property (@(posedge clk) disable iff (rst) init_busy |-> !q_push)
    else $error("command queued during counter clear");

  // a full queue never takes another command unless one leaves
  assert property (@(posedge clk) disable iff (rst) (q_full && !q_pop) |-> !q_push)
    else $error("command queue overrun");

  // an empty queue is never popped
  assert property (@(posedge clk) disable iff (rst) q_empty |-> !q_pop)
    else $error("pop from empty command queue");

  // a get on an empty ring carries no chunk
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_NO_WORK) |->
      (result.chunk_count == '0 && result.remaining == '0 && result.handle_out == '0))
    else $error("no-work result carries chunk data");

endmodule
